// ===== hdl/qac_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package qac_pkg;

    // Default queue depth
    localparam int DEF_QUEUE_DEPTH = 64;

    // Configuration port widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLICY     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_MARK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_MARK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NOTICE_EN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DECISION_EN = 3'd5;

    // Register reset values
    localparam logic [6:0] RST_CAPACITY  = 7'd64;
    localparam logic [2:0] RST_POLICY    = 3'd2;
    localparam logic [8:0] RST_HIGH_MARK = 9'd205;
    localparam logic [8:0] RST_LOW_MARK  = 9'd128;

    // Operation codes
    localparam logic [1:0] OP_ENQ   = 2'd0;
    localparam logic [1:0] OP_BATCH = 2'd1;
    localparam logic [1:0] OP_DEQ   = 2'd2;

    // Full-queue policies
    localparam logic [2:0] POL_BLOCK    = 3'd0;
    localparam logic [2:0] POL_DROP_OLD = 3'd1;
    localparam logic [2:0] POL_DROP_NEW = 3'd2;
    localparam logic [2:0] POL_CALLBACK = 3'd3;
    localparam logic [2:0] POL_ADAPTIVE = 3'd4;

    // External verdicts
    localparam logic [1:0] DEC_ACCEPT = 2'd0;
    localparam logic [1:0] DEC_REJECT = 2'd1;
    localparam logic [1:0] DEC_DROP   = 2'd2;
    localparam logic [1:0] DEC_DELAY  = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_TIMEOUT = 3'd2;
    localparam logic [2:0] ST_BUSY    = 3'd3;
    localparam logic [2:0] ST_INVALID = 3'd4;

    // Pressure levels
    localparam logic [1:0] LVL_NONE = 2'd0;
    localparam logic [1:0] LVL_LOW  = 2'd1;
    localparam logic [1:0] LVL_HIGH = 2'd2;
    localparam logic [1:0] LVL_CRIT = 2'd3;

    // Effective configuration seen by the decision logic
    typedef struct packed {
        logic [6:0]  cap;
        logic [2:0]  policy;
        logic [15:0] high_thr;
        logic [15:0] low_thr;
        logic        notice_en;
        logic        decision_en;
    } t_cfg;

    // One result beat
    typedef struct packed {
        logic [2:0] status;
        logic [6:0] accepted_n;
        logic [6:0] dropped_n;
        logic [6:0] occupancy_now;
        logic [1:0] level_now;
        logic       notice;
        logic [1:0] pressure_events_n;
    } t_res;

endpackage

`default_nettype wire

// ===== hdl/qac_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qac_cfg
    import qac_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_wr_valid,
    output logic                       o_wr_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_wr_index,
    input  wire logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                       o_cfg
);

    logic [6:0] r_capacity;
    logic [2:0] r_policy;
    logic [8:0] r_high_mark;
    logic [8:0] r_low_mark;
    logic       r_notice_en;
    logic       r_decision_en;
    logic [6:0] eff_cap;

    // Always take writes
    assign o_wr_ready = 1'b1;

    // Store register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity    <= RST_CAPACITY;
            r_policy      <= RST_POLICY;
            r_high_mark   <= RST_HIGH_MARK;
            r_low_mark    <= RST_LOW_MARK;
            r_notice_en   <= 1'b0;
            r_decision_en <= 1'b0;
        end else if (i_wr_valid) begin
            case (i_wr_index)
                REG_CAPACITY:    r_capacity    <= i_wr_data[6:0];
                REG_POLICY:      r_policy      <= i_wr_data[2:0];
                REG_HIGH_MARK:   r_high_mark   <= i_wr_data[8:0];
                REG_LOW_MARK:    r_low_mark    <= i_wr_data[8:0];
                REG_NOTICE_EN:   r_notice_en   <= i_wr_data[0];
                REG_DECISION_EN: r_decision_en <= i_wr_data[0];
                default: ;
            endcase
        end
    end

    // Clamp capacity to [1, depth]
    always_comb begin
        if (r_capacity == 7'd0) begin
            eff_cap = 7'd1;
        end else if (32'(r_capacity) > QUEUE_DEPTH) begin
            eff_cap = 7'(QUEUE_DEPTH);
        end else begin
            eff_cap = r_capacity;
        end
    end

    // Scale watermarks by capacity so a compare against occupancy*256 is exact
    always_comb begin
        o_cfg.cap         = eff_cap;
        o_cfg.policy      = r_policy;
        o_cfg.high_thr    = 16'(r_high_mark) * 16'(eff_cap);
        o_cfg.low_thr     = 16'(r_low_mark) * 16'(eff_cap);
        o_cfg.notice_en   = r_notice_en;
        o_cfg.decision_en = r_decision_en;
    end

endmodule

`default_nettype wire

// ===== hdl/qac_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qac_core
    import qac_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int OCC_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic [1:0]       i_op,
    input  wire logic [6:0]       i_batch_count,
    input  wire logic [1:0]       i_decision,
    input  wire t_cfg             i_cfg,
    input  wire logic [OCC_W-1:0] i_occ,
    input  wire logic [1:0]       i_level,
    output logic [OCC_W-1:0]      o_occ,
    output t_res                  o_res
);

    // Working width: occupancy or batch size plus one carry bit
    localparam int CW = ((OCC_W > 7) ? OCC_W : 7) + 1;
    // Width of occupancy*256 and of the scaled watermarks
    localparam int PW = ((OCC_W + 8) > 16) ? (OCC_W + 8) : 16;

    logic [CW-1:0] occ_x;
    logic [CW-1:0] cap_x;
    logic [CW-1:0] n_x;
    logic [CW-1:0] avail;
    logic [CW-1:0] want;
    logic [CW-1:0] drop_x;
    logic [CW-1:0] left_x;
    logic [CW-1:0] nocc;
    logic [CW-1:0] acc;
    logic [CW-1:0] drop;
    logic [PW-1:0] occ_p;
    logic [PW-1:0] nocc_p;
    logic [PW-1:0] high_p;
    logic [PW-1:0] low_p;
    logic [2:0]    status;
    logic          full;
    logic          do_lvl;
    logic          drop_one;
    logic          ev_extra;
    logic [1:0]    lvl;
    logic          notice;
    logic          lvl_ev;

    assign occ_x  = CW'(i_occ);
    assign cap_x  = CW'(i_cfg.cap);
    assign n_x    = CW'(i_batch_count);
    assign full   = occ_x >= cap_x;
    assign avail  = (cap_x > occ_x) ? (cap_x - occ_x) : '0;
    assign want   = n_x - avail;
    assign drop_x = (want < occ_x) ? want : occ_x;
    assign left_x = occ_x - drop_x;
    assign occ_p  = PW'(i_occ) << 8;
    assign high_p = PW'(i_cfg.high_thr);
    assign low_p  = PW'(i_cfg.low_thr);

    // Admission decision
    always_comb begin
        status   = ST_OK;
        acc      = '0;
        drop     = '0;
        nocc     = occ_x;
        do_lvl   = 1'b0;
        drop_one = 1'b0;
        ev_extra = 1'b0;
        case (i_op)
            OP_ENQ: begin
                if (!full) begin
                    nocc   = occ_x + CW'(1);
                    acc    = CW'(1);
                    do_lvl = 1'b1;
                end else begin
                    case (i_cfg.policy)
                        POL_CALLBACK: begin
                            if (!i_cfg.decision_en) begin
                                status = ST_FULL;
                            end else begin
                                case (i_decision)
                                    DEC_ACCEPT: begin
                                        // forced admission up to the physical depth
                                        if (occ_x < CW'(QUEUE_DEPTH)) begin
                                            nocc = occ_x + CW'(1);
                                            acc  = CW'(1);
                                        end else begin
                                            status = ST_FULL;
                                        end
                                    end
                                    DEC_REJECT: status   = ST_FULL;
                                    DEC_DROP:   drop_one = 1'b1;
                                    DEC_DELAY:  status   = ST_BUSY;
                                    default:    status   = ST_FULL;
                                endcase
                            end
                        end
                        POL_BLOCK:    status   = ST_TIMEOUT;
                        POL_DROP_OLD: drop_one = 1'b1;
                        POL_DROP_NEW: begin
                            status   = ST_FULL;
                            ev_extra = 1'b1;
                            do_lvl   = 1'b1;
                        end
                        POL_ADAPTIVE: begin
                            status   = ST_FULL;
                            ev_extra = occ_p >= high_p;
                            do_lvl   = 1'b1;
                        end
                        default: status = ST_FULL;
                    endcase
                    // drop the oldest job and admit the new one
                    if (drop_one) begin
                        if (occ_x != '0) begin
                            drop = CW'(1);
                            nocc = occ_x;
                        end else begin
                            nocc = occ_x + CW'(1);
                        end
                        acc    = CW'(1);
                        do_lvl = 1'b1;
                    end
                end
            end
            OP_BATCH: begin
                if (n_x == '0) begin
                    status = ST_INVALID;
                end else if (n_x <= avail) begin
                    nocc   = occ_x + n_x;
                    acc    = n_x;
                    do_lvl = 1'b1;
                end else begin
                    case (i_cfg.policy)
                        POL_DROP_OLD: begin
                            // drops stand even when the batch still does not fit
                            drop = drop_x;
                            if ((left_x + n_x) <= cap_x) begin
                                nocc = left_x + n_x;
                                acc  = n_x;
                            end else begin
                                nocc   = left_x;
                                status = ST_FULL;
                            end
                            do_lvl = 1'b1;
                        end
                        POL_BLOCK: status = ST_TIMEOUT;
                        default: begin
                            status   = ST_FULL;
                            ev_extra = 1'b1;
                            do_lvl   = 1'b1;
                        end
                    endcase
                end
            end
            OP_DEQ: begin
                if (occ_x != '0) begin
                    nocc = occ_x - CW'(1);
                end
            end
            default: status = ST_INVALID;
        endcase
    end

    assign nocc_p = PW'(nocc) << 8;

    // Pressure level and notice
    always_comb begin
        lvl    = i_level;
        notice = 1'b0;
        lvl_ev = 1'b0;
        if (do_lvl) begin
            if (nocc >= cap_x) begin
                lvl = LVL_CRIT;
            end else if (nocc_p >= high_p) begin
                lvl = LVL_HIGH;
            end else if (nocc_p >= low_p) begin
                lvl = LVL_LOW;
            end else begin
                lvl = LVL_NONE;
            end
            notice = i_cfg.notice_en && ((lvl != i_level) || lvl[1]);
            lvl_ev = notice && lvl[1];
        end
    end

    // Pack the result
    always_comb begin
        o_occ                   = nocc[OCC_W-1:0];
        o_res.status            = status;
        o_res.accepted_n        = acc[6:0];
        o_res.dropped_n         = drop[6:0];
        o_res.occupancy_now     = nocc[6:0];
        o_res.level_now         = lvl;
        o_res.notice            = notice;
        o_res.pressure_events_n = 2'(ev_extra) + 2'(lvl_ev);
    end

endmodule

`default_nettype wire

// ===== hdl/queue_admission_controller_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Admission controller for a bounded job queue.
// Input channel (i_in_valid / o_in_stall): one beat per request, carrying
// i_op (enqueue one, enqueue batch, dequeue one), i_batch_count and the
// external verdict i_decision. Output channel (o_out_valid / i_out_stall):
// one beat per request with status, admitted and dropped counts, occupancy,
// pressure level, notice and pressure event count.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): register index
// and data; write only while no request is in flight.
// Path: a request is decided combinationally while it sits in the input
// register and lands in the output register, which raises o_out_valid,
// once the output register is empty or being drained.
// Throughput: one request per cycle while the output is not stalled; the
// occupancy and level registers update at the same edge as the result
// register, so the next request sees them without a bubble.
// Reset: occupancy and level clear, registers take their defaults
// (capacity 64, drop newest, marks 205/256 and 128/256, callbacks off).
// Stall: a stalled output beat holds; the input register then holds too
// and o_in_stall rises while it is full.
module queue_admission_controller_unit
    import qac_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [1:0]            i_op,
    input  wire logic [6:0]            i_batch_count,
    input  wire logic [1:0]            i_decision,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [2:0]                 o_status,
    output logic [6:0]                 o_accepted_n,
    output logic [6:0]                 o_dropped_n,
    output logic [6:0]                 o_occupancy_now,
    output logic [1:0]                 o_level_now,
    output logic                       o_notice,
    output logic [1:0]                 o_pressure_events_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    t_cfg             cfg;
    t_res             res;
    logic [OCC_W-1:0] core_occ;

    logic             r_in_vld;
    logic [1:0]       r_in_op;
    logic [6:0]       r_in_batch;
    logic [1:0]       r_in_dec;
    logic [OCC_W-1:0] r_occ;
    logic [1:0]       r_level;
    logic             r_out_vld;
    t_res             r_res;

    logic             out_free;
    logic             fire;
    logic             in_take;

    qac_cfg #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg_valid),
        .o_wr_ready (o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    qac_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .OCC_W       (OCC_W)
    ) u_core (
        .i_op          (r_in_op),
        .i_batch_count (r_in_batch),
        .i_decision    (r_in_dec),
        .i_cfg         (cfg),
        .i_occ         (r_occ),
        .i_level       (r_level),
        .o_occ         (core_occ),
        .o_res         (res)
    );

    // Advance when the output register is empty or being drained
    assign out_free   = !r_out_vld || !i_out_stall;
    assign fire       = r_in_vld && out_free;
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_vld && !out_free;

    // Input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    // Input register payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op    <= i_op;
            r_in_batch <= i_batch_count;
            r_in_dec   <= i_decision;
        end
    end

    // Queue state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ     <= '0;
            r_level   <= LVL_NONE;
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_occ     <= core_occ;
            r_level   <= res.level_now;
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= res;
        end
    end

    assign o_out_valid         = r_out_vld;
    assign o_status            = r_res.status;
    assign o_accepted_n        = r_res.accepted_n;
    assign o_dropped_n         = r_res.dropped_n;
    assign o_occupancy_now     = r_res.occupancy_now;
    assign o_level_now         = r_res.level_now;
    assign o_notice            = r_res.notice;
    assign o_pressure_events_n = r_res.pressure_events_n;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import qac_pkg::*;

    localparam int DEPTH      = DEF_QUEUE_DEPTH;
    localparam int PLAN_N     = 6;
    localparam int PHASE_N    = 15;
    localparam int PHASE_JOBS = 130;
    localparam int WATCHDOG   = 400;

    // Codes the package leaves out: the spare operation and a policy past adaptive
    localparam logic [1:0] OP_BAD      = 2'd3;
    localparam logic [2:0] POL_UNKNOWN = 3'd7;
    // Marks a full-queue enqueue whose callback verdict already settled it
    localparam int unsigned MODE_DONE  = 7;

    typedef struct packed {
        logic [1:0] op;
        logic [6:0] cnt;
        logic [1:0] dec;
    } t_req;

    typedef struct packed {
        logic [6:0] cap;
        logic [2:0] pol;
        logic [8:0] hi;
        logic [8:0] lo;
        logic       ne;
        logic       de;
    } t_plan;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [1:0]            i_op = '0;
    logic [6:0]            i_batch_count = '0;
    logic [1:0]            i_decision = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [2:0]            o_status;
    logic [6:0]            o_accepted_n;
    logic [6:0]            o_dropped_n;
    logic [6:0]            o_occupancy_now;
    logic [1:0]            o_level_now;
    logic                  o_notice;
    logic [1:0]            o_pressure_events_n;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    queue_admission_controller_unit dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_op                (i_op),
        .i_batch_count       (i_batch_count),
        .i_decision          (i_decision),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_status            (o_status),
        .o_accepted_n        (o_accepted_n),
        .o_dropped_n         (o_dropped_n),
        .o_occupancy_now     (o_occupancy_now),
        .o_level_now         (o_level_now),
        .o_notice            (o_notice),
        .o_pressure_events_n (o_pressure_events_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow registers and queue state of the admission controller
    int unsigned m_cap = RST_CAPACITY;
    int unsigned m_pol = RST_POLICY;
    int unsigned m_hi  = RST_HIGH_MARK;
    int unsigned m_lo  = RST_LOW_MARK;
    int unsigned m_note_en = 0;
    int unsigned m_dec_en  = 0;
    int unsigned occ = 0;
    int unsigned lvl = LVL_NONE;
    int unsigned fire;
    int unsigned events;

    t_req job_requests[$];
    t_res due_verdicts[$];

    bit          quiet = 1'b0;
    bit          in_beat = 1'b0;
    int unsigned gap_n = 0;
    int unsigned hold_n = 0;
    int unsigned posted_n = 0;
    int unsigned taken_n = 0;
    int unsigned result_n = 0;
    int unsigned refused_n = 0;
    int unsigned notice_n = 0;
    int unsigned write_n = 0;
    int unsigned idle_n = 0;
    int unsigned err_n = 0;

    function automatic int unsigned eff_capacity();
        if (m_cap == 0) return 1;
        if (m_cap > DEPTH) return DEPTH;
        return m_cap;
    endfunction

    // Recompute the pressure level from occupancy and raise the notice
    function automatic void settle_level();
        int unsigned c;
        int unsigned nl;
        c = eff_capacity();
        if (occ >= c) nl = LVL_CRIT;
        else if (occ * 256 >= m_hi * c) nl = LVL_HIGH;
        else if (occ * 256 >= m_lo * c) nl = LVL_LOW;
        else nl = LVL_NONE;
        if (m_note_en != 0 && (nl != lvl || nl >= LVL_HIGH)) begin
            fire = 1;
            if (nl >= LVL_HIGH) events++;
        end
        lvl = nl;
    endfunction

    // Decide one request and advance occupancy and level
    function automatic t_res admit_request(t_req r);
        t_res        res;
        int unsigned c;
        int unsigned n;
        int unsigned avail;
        int unsigned want;
        int unsigned mode;
        int unsigned st;
        int unsigned acc;
        int unsigned drop;
        c = eff_capacity();
        n = r.cnt;
        st = ST_OK;
        acc = 0;
        drop = 0;
        fire = 0;
        events = 0;
        case (r.op)
            OP_ENQ: begin
                if (occ < c) begin
                    occ++;
                    acc = 1;
                    settle_level();
                end else begin
                    mode = m_pol;
                    if (m_pol == POL_CALLBACK) begin
                        mode = MODE_DONE;
                        if (m_dec_en == 0) begin
                            st = ST_FULL;
                        end else begin
                            case (r.dec)
                                DEC_ACCEPT: begin
                                    // forced admission past capacity, held at depth
                                    if (occ < DEPTH) begin
                                        occ++;
                                        acc = 1;
                                    end else begin
                                        st = ST_FULL;
                                    end
                                end
                                DEC_REJECT: st = ST_FULL;
                                DEC_DROP:   mode = POL_DROP_OLD;
                                default:    st = ST_BUSY;
                            endcase
                        end
                    end
                    if (mode == POL_BLOCK) begin
                        st = ST_TIMEOUT;
                    end else if (mode == POL_DROP_OLD) begin
                        if (occ > 0) begin
                            occ--;
                            drop = 1;
                        end
                        occ++;
                        acc = 1;
                        settle_level();
                    end else if (mode == POL_DROP_NEW) begin
                        st = ST_FULL;
                        events++;
                        settle_level();
                    end else if (mode == POL_ADAPTIVE) begin
                        st = ST_FULL;
                        if (occ * 256 >= m_hi * c) events++;
                        settle_level();
                    end else if (m_pol != POL_CALLBACK) begin
                        st = ST_FULL;
                    end
                end
            end
            OP_BATCH: begin
                if (n == 0) begin
                    st = ST_INVALID;
                end else begin
                    avail = (c > occ) ? c - occ : 0;
                    if (n <= avail) begin
                        occ += n;
                        acc = n;
                        settle_level();
                    end else if (m_pol == POL_DROP_OLD) begin
                        // make room from the oldest jobs; drops stand even if it still fails
                        want = n - avail;
                        drop = (want < occ) ? want : occ;
                        occ -= drop;
                        if (occ + n <= c) begin
                            occ += n;
                            acc = n;
                        end else begin
                            st = ST_FULL;
                        end
                        settle_level();
                    end else if (m_pol == POL_BLOCK) begin
                        st = ST_TIMEOUT;
                    end else begin
                        st = ST_FULL;
                        events++;
                        settle_level();
                    end
                end
            end
            OP_DEQ: begin
                if (occ > 0) occ--;
            end
            default: st = ST_INVALID;
        endcase
        res.status            = st[2:0];
        res.accepted_n        = acc[6:0];
        res.dropped_n         = drop[6:0];
        res.occupancy_now     = occ[6:0];
        res.level_now         = lvl[1:0];
        res.notice            = fire[0];
        res.pressure_events_n = events[1:0];
        return res;
    endfunction

    function automatic void check_field(string name, logic [6:0] want, logic [6:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            err_n++;
        end
    endfunction

    // Present request beats; hold a beat until it is taken
    always @(negedge i_clk) begin : request_driver
        t_req r;
        if (i_rst_n && (!i_in_valid || in_beat)) begin
            if (gap_n > 0 || job_requests.size() == 0) begin
                if (gap_n > 0) gap_n--;
                i_in_valid <= 1'b0;
            end else begin
                r = job_requests.pop_front();
                i_in_valid    <= 1'b1;
                i_op          <= r.op;
                i_batch_count <= r.cnt;
                i_decision    <= r.dec;
                if (!quiet && $urandom_range(0, 9) == 0) gap_n = $urandom_range(1, 9);
            end
        end
    end

    // Stall the result side in bursts
    always @(negedge i_clk) begin : result_stall
        if (hold_n > 0) begin
            hold_n--;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
            hold_n = $urandom_range(0, 8);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Predict on each request beat, check each result beat, watch for progress
    always @(posedge i_clk) begin : scoreboard
        t_res want;
        bit   moved;
        moved = 1'b0;
        if (i_rst_n) begin
            in_beat = i_in_valid && !o_in_stall;
            if (in_beat) begin
                due_verdicts.push_back(admit_request('{i_op, i_batch_count, i_decision}));
                taken_n++;
                moved = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (due_verdicts.size() == 0) begin
                    $display("%0t: result beat with nothing expected, status %0d",
                             $time, o_status);
                    err_n++;
                end else begin
                    want = due_verdicts.pop_front();
                    check_field("status", 7'(want.status), 7'(o_status));
                    check_field("accepted_n", want.accepted_n, o_accepted_n);
                    check_field("dropped_n", want.dropped_n, o_dropped_n);
                    check_field("occupancy_now", want.occupancy_now, o_occupancy_now);
                    check_field("level_now", 7'(want.level_now), 7'(o_level_now));
                    check_field("notice", 7'(want.notice), 7'(o_notice));
                    check_field("pressure_events_n", 7'(want.pressure_events_n),
                                7'(o_pressure_events_n));
                    result_n++;
                    if (want.status == ST_FULL || want.status == ST_TIMEOUT ||
                        want.status == ST_BUSY) refused_n++;
                    if (want.notice) notice_n++;
                end
            end
            if (i_cfg_valid && o_cfg_ready) moved = 1'b1;
            if (moved) idle_n = 0;
            else idle_n++;
            if (idle_n >= WATCHDOG) begin
                $display("%0t: no beat moved for %0d cycles", $time, idle_n);
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    task automatic post(logic [1:0] op, logic [6:0] cnt, logic [1:0] dec);
        job_requests.push_back('{op, cnt, dec});
        posted_n++;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (taken_n != posted_n || due_verdicts.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        write_n++;
        case (idx)
            REG_CAPACITY:    m_cap = val[6:0];
            REG_POLICY:      m_pol = val[2:0];
            REG_HIGH_MARK:   m_hi = val;
            REG_LOW_MARK:    m_lo = val;
            REG_NOTICE_EN:   m_note_en = val[0];
            REG_DECISION_EN: m_dec_en = val[0];
            default: ;
        endcase
    endtask

    task automatic program_regs(t_plan c);
        write_reg(REG_CAPACITY, {2'b00, c.cap});
        write_reg(REG_POLICY, {6'd0, c.pol});
        write_reg(REG_HIGH_MARK, c.hi);
        write_reg(REG_LOW_MARK, c.lo);
        write_reg(REG_NOTICE_EN, {8'd0, c.ne});
        write_reg(REG_DECISION_EN, {8'd0, c.de});
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        t_plan       plan [PLAN_N];
        t_plan       c;
        t_req        r;
        int unsigned k;
        int unsigned j;
        int unsigned ec;
        int unsigned deq_pct;

        plan[0] = '{7'd1,   POL_DROP_OLD, 9'd0,   9'd0,   1'b1, 1'b0};
        plan[1] = '{7'd64,  POL_CALLBACK, 9'd256, 9'd256, 1'b1, 1'b1};
        plan[2] = '{7'd0,   POL_BLOCK,    9'd511, 9'd0,   1'b1, 1'b0};
        plan[3] = '{7'd127, POL_ADAPTIVE, 9'd205, 9'd128, 1'b1, 1'b1};
        plan[4] = '{7'd2,   POL_UNKNOWN,  9'd128, 9'd64,  1'b1, 1'b1};
        plan[5] = '{7'd8,   POL_ADAPTIVE, 9'd300, 9'd100, 1'b1, 1'b0};

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: empty dequeue, bad op, empty and oversized batches, full queue
        post(OP_DEQ, 7'd0, DEC_ACCEPT);
        post(OP_BAD, 7'd127, DEC_DELAY);
        post(OP_BATCH, 7'd0, DEC_ACCEPT);
        post(OP_BATCH, 7'd127, DEC_ACCEPT);
        post(OP_BATCH, 7'd64, DEC_ACCEPT);
        post(OP_ENQ, 7'd0, DEC_ACCEPT);
        post(OP_BATCH, 7'd1, DEC_ACCEPT);
        post(OP_DEQ, 7'd0, DEC_ACCEPT);
        post(OP_ENQ, 7'd0, DEC_ACCEPT);
        wait_drained();

        // Small queue under callback: fill it, then each verdict once
        program_regs('{7'd4, POL_CALLBACK, 9'd192, 9'd64, 1'b1, 1'b1});
        repeat (4) post(OP_ENQ, 7'd0, DEC_REJECT);
        post(OP_ENQ, 7'd0, DEC_ACCEPT);
        post(OP_ENQ, 7'd0, DEC_REJECT);
        post(OP_ENQ, 7'd0, DEC_DROP);
        post(OP_ENQ, 7'd0, DEC_DELAY);
        post(OP_BATCH, 7'd6, DEC_ACCEPT);
        post(OP_DEQ, 7'd0, DEC_ACCEPT);

        for (int ph = 0; ph < PHASE_N; ph++) begin
            wait_drained();
            if (ph < PLAN_N) begin
                c = plan[ph];
            end else begin
                k = $urandom_range(0, 9);
                if (k == 0) c.cap = 7'd0;
                else if (k == 1) c.cap = 7'($urandom_range(65, 127));
                else if (k == 2) c.cap = 7'd64;
                else c.cap = 7'($urandom_range(1, 16));
                k = $urandom_range(0, 11);
                c.pol = 3'((k < 10) ? k % 5 : $urandom_range(5, 7));
                c.hi = ($urandom_range(0, 7) == 0) ? 9'd511 : 9'($urandom_range(0, 300));
                c.lo = 9'($urandom_range(0, 300));
                c.ne = ($urandom_range(0, 3) != 0);
                c.de = 1'($urandom_range(0, 1));
            end
            if (ph == PHASE_N - 1) quiet = 1'b1;
            program_regs(c);

            // Lean toward enqueues so full-queue handling is reached often
            ec = (c.cap == 0) ? 1 : (c.cap > DEPTH) ? DEPTH : c.cap;
            deq_pct = $urandom_range(8, 45);
            repeat (PHASE_JOBS) begin
                k = $urandom_range(0, 99);
                r.dec = 2'($urandom_range(0, 3));
                r.cnt = 7'($urandom_range(0, 127));
                if (k < 2) begin
                    r.op = OP_BAD;
                end else if (k < 2 + deq_pct) begin
                    r.op = OP_DEQ;
                end else if (k < 30 + deq_pct) begin
                    r.op = OP_BATCH;
                    j = $urandom_range(0, 19);
                    if (j == 0) r.cnt = 7'd0;
                    else if (j == 1) r.cnt = 7'($urandom_range(65, 127));
                    else if (j == 2) r.cnt = 7'd64;
                    else r.cnt = 7'($urandom_range(1, ec + 2));
                end else begin
                    r.op = OP_ENQ;
                end
                post(r.op, r.cnt, r.dec);
            end
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (due_verdicts.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, due_verdicts.size());
            err_n++;
        end
        $display("Covered %0d requests over %0d register settings with %0d register writes.",
                 taken_n, PHASE_N + 2, write_n);
        $display("Checked %0d results: %0d refused or deferred, %0d with a pressure notice.",
                 result_n, refused_n, notice_n);
        if (err_n == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
